[rtl/pidpi_pkg.sv]
// Shared types and constants for the positional and incremental PID controller.
package pidpi_pkg;

	localparam int GAIN_WIDTH      = 16;
	localparam int LIMIT_WIDTH     = 15;
	localparam int DEADBAND_WIDTH  = 16;
	localparam int STATE_WIDTH     = 16;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P    = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I    = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D    = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SUM_LIMIT = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_LIMIT = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADBAND  = 3'd6;

	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	localparam logic [DEADBAND_WIDTH-1:0] DEADBAND_RESET = 16'd1;

	typedef struct packed {
		logic                      mode;
		logic [GAIN_WIDTH-1:0]     gain_p;
		logic [GAIN_WIDTH-1:0]     gain_i;
		logic [GAIN_WIDTH-1:0]     gain_d;
		logic [LIMIT_WIDTH-1:0]    sum_limit;
		logic [LIMIT_WIDTH-1:0]    out_limit;
		logic [DEADBAND_WIDTH-1:0] deadband;
	} cfg_t;

endpackage

[rtl/pidpi_cfg_regs.sv]
// Configuration register file of the PID controller.
module pidpi_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pidpi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [pidpi_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	output pidpi_pkg::cfg_t                       cfg
);
	import pidpi_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_POSITIONAL;
			cfg_q.gain_p    <= '0;
			cfg_q.gain_i    <= '0;
			cfg_q.gain_d    <= '0;
			cfg_q.sum_limit <= '0;
			cfg_q.out_limit <= '0;
			cfg_q.deadband  <= DEADBAND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:      cfg_q.mode      <= cfg_data[0];
				REG_GAIN_P:    cfg_q.gain_p    <= cfg_data[GAIN_WIDTH-1:0];
				REG_GAIN_I:    cfg_q.gain_i    <= cfg_data[GAIN_WIDTH-1:0];
				REG_GAIN_D:    cfg_q.gain_d    <= cfg_data[GAIN_WIDTH-1:0];
				REG_SUM_LIMIT: cfg_q.sum_limit <= cfg_data[LIMIT_WIDTH-1:0];
				REG_OUT_LIMIT: cfg_q.out_limit <= cfg_data[LIMIT_WIDTH-1:0];
				REG_DEADBAND:  cfg_q.deadband  <= cfg_data[DEADBAND_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/pidpi_datapath.sv]
// Combinational PID step: error terms, gain products, clamps and next state.
module pidpi_datapath #(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  pidpi_pkg::cfg_t                           cfg,
	input  logic signed [DATA_WIDTH-1:0]              target,
	input  logic signed [DATA_WIDTH-1:0]              current,
	input  logic signed [pidpi_pkg::STATE_WIDTH-1:0]  integral,
	input  logic signed [DATA_WIDTH:0]                last_error,
	input  logic signed [DATA_WIDTH:0]                older_error,
	input  logic signed [pidpi_pkg::STATE_WIDTH-1:0]  held_drive,
	output logic signed [DATA_WIDTH-1:0]              drive_next,
	output logic signed [pidpi_pkg::STATE_WIDTH-1:0]  integral_next,
	output logic signed [DATA_WIDTH:0]                last_error_next,
	output logic signed [DATA_WIDTH:0]                older_error_next,
	output logic signed [pidpi_pkg::STATE_WIDTH-1:0]  held_drive_next
);
	import pidpi_pkg::*;

	localparam int EW  = DATA_WIDTH + 1;
	localparam int D1W = DATA_WIDTH + 2;
	localparam int D2W = DATA_WIDTH + 3;
	localparam int PW  = D2W + GAIN_WIDTH;
	localparam int SW  = PW + 3;

	function automatic logic signed [SW-1:0] clamp_sym(input logic signed [SW-1:0] x,
	                                                 input logic [LIMIT_WIDTH-1:0] lim);
		logic signed [SW-1:0] lim_s;
		lim_s = signed'(SW'(lim));
		if (x > lim_s)
			return lim_s;
		else if (x < -lim_s)
			return -lim_s;
		else
			return x;
	endfunction

	logic signed [EW-1:0]  err;
	logic signed [D1W-1:0] diff1;
	logic signed [D2W-1:0] diff2;
	logic signed [D2W-1:0] op_p;
	logic signed [D2W-1:0] op_i;
	logic signed [D2W-1:0] op_d;
	logic signed [PW-1:0]  prod_p;
	logic signed [PW-1:0]  prod_i;
	logic signed [PW-1:0]  prod_d;
	logic signed [SW-1:0]  term_p;
	logic signed [SW-1:0]  term_i;
	logic signed [SW-1:0]  term_d;
	logic signed [SW-1:0]  integ_clamped;
	logic signed [SW-1:0]  pos_full;
	logic signed [SW-1:0]  inc_sum;
	logic signed [SW-1:0]  drive_clamped;
	logic signed [SW-1:0]  band_s;
	logic signed [SW-1:0]  diff1_s;
	logic                  in_band;
	logic                  incr;

	assign incr = (cfg.mode == MODE_INCREMENTAL);

	assign err   = EW'(target) - EW'(current);
	assign diff1 = D1W'(err) - D1W'(last_error);
	assign diff2 = D2W'(err) - (D2W'(last_error) <<< 1) + D2W'(older_error);

	// The two modes feed the P and D multipliers with different error operands.
	assign op_p = incr ? D2W'(diff1) : D2W'(err);
	assign op_i = D2W'(err);
	assign op_d = incr ? diff2 : D2W'(diff1);

	assign prod_p = PW'(op_p) * PW'($signed(cfg.gain_p));
	assign prod_i = PW'(op_i) * PW'($signed(cfg.gain_i));
	assign prod_d = PW'(op_d) * PW'($signed(cfg.gain_d));

	// Arithmetic shifts round the Q8.8 products toward minus infinity.
	assign term_p = SW'(prod_p >>> GAIN_FRAC_BITS);
	assign term_i = SW'(prod_i >>> GAIN_FRAC_BITS);
	assign term_d = SW'(prod_d >>> GAIN_FRAC_BITS);

	assign integ_clamped = clamp_sym(SW'(integral) + term_i, cfg.sum_limit);
	assign pos_full      = term_p + integ_clamped + term_d;
	assign inc_sum       = SW'(held_drive) + term_p + term_i + term_d;

	assign band_s  = signed'(SW'(cfg.deadband));
	assign diff1_s = SW'(diff1);
	assign in_band = (diff1_s > -band_s) && (diff1_s < band_s);

	always_comb begin
		if (incr)
			drive_clamped = clamp_sym(inc_sum, cfg.out_limit);
		else if (in_band)
			drive_clamped = clamp_sym(term_p, cfg.out_limit);
		else
			drive_clamped = clamp_sym(pos_full, cfg.out_limit);
	end

	assign drive_next       = drive_clamped[DATA_WIDTH-1:0];
	assign held_drive_next  = drive_clamped[STATE_WIDTH-1:0];
	assign integral_next    = incr ? integral : integ_clamped[STATE_WIDTH-1:0];
	assign last_error_next  = err;
	assign older_error_next = incr ? last_error : older_error;

endmodule

[rtl/pid_positional_incremental.sv]
// Top level of the positional and incremental PID controller.
// A request waits in the input stage; its drive is then held in the output register.
// Throughput: one request per cycle while drives are taken; the controller state loop
// closes through the three gain multipliers and the clamps of the datapath.
// Reset clears the controller state, the gains and limits, and sets the deadband to one.
// The input stage accepts a new request while a finished drive waits to be taken.
module pid_positional_incremental #(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [DATA_WIDTH-1:0]          target,
	input  logic signed [DATA_WIDTH-1:0]          current,
	output logic                                  drive_valid,
	input  logic                                  drive_ready,
	output logic signed [DATA_WIDTH-1:0]          drive,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pidpi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [pidpi_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	import pidpi_pkg::*;

	cfg_t cfg;

	// Input stage holding one request.
	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] target_s1;
	logic signed [DATA_WIDTH-1:0] current_s1;

	// Controller state, updated once for every request that moves to the output.
	logic signed [STATE_WIDTH-1:0] integral_q;
	logic signed [DATA_WIDTH:0]    last_error_q;
	logic signed [DATA_WIDTH:0]    older_error_q;
	logic signed [STATE_WIDTH-1:0] held_drive_q;

	// Output register.
	logic                         drive_valid_q;
	logic signed [DATA_WIDTH-1:0] drive_q;

	logic signed [DATA_WIDTH-1:0]  drive_next;
	logic signed [STATE_WIDTH-1:0] integral_next;
	logic signed [DATA_WIDTH:0]    last_error_next;
	logic signed [DATA_WIDTH:0]    older_error_next;
	logic signed [STATE_WIDTH-1:0] held_drive_next;

	logic advance;
	logic sample_accept;

	pidpi_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidpi_datapath #(
		.DATA_WIDTH     (DATA_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_datapath (
		.cfg              (cfg),
		.target           (target_s1),
		.current          (current_s1),
		.integral         (integral_q),
		.last_error       (last_error_q),
		.older_error      (older_error_q),
		.held_drive       (held_drive_q),
		.drive_next       (drive_next),
		.integral_next    (integral_next),
		.last_error_next  (last_error_next),
		.older_error_next (older_error_next),
		.held_drive_next  (held_drive_next)
	);

	// The held request is processed when the output register is empty or is being
	// emptied in the same cycle, so the state advances exactly once per request.
	assign advance       = valid_s1 && (!drive_valid_q || drive_ready);
	assign sample_ready  = !valid_s1 || advance;
	assign sample_accept = sample_valid && sample_ready;

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			drive_valid_q <= 1'b0;
			integral_q    <= '0;
			last_error_q  <= '0;
			older_error_q <= '0;
			held_drive_q  <= '0;
		end else begin
			if (sample_accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				drive_valid_q <= 1'b1;
			else if (drive_ready)
				drive_valid_q <= 1'b0;

			if (advance) begin
				integral_q    <= integral_next;
				last_error_q  <= last_error_next;
				older_error_q <= older_error_next;
				held_drive_q  <= held_drive_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_accept) begin
			target_s1  <= target;
			current_s1 <= current;
		end
		if (advance)
			drive_q <= drive_next;
	end

endmodule

[tb/pid_positional_incremental_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the positional and incremental PID controller.
module pid_positional_incremental_test;
	import pidpi_pkg::*;

	localparam int DATA_WIDTH     = 16;
	localparam int GAIN_FRAC_BITS = 8;
	// Watchdog limit, set with a wide margin over a slow correct run.
	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_SAMPLES  = 92;
	localparam int PRESSURE_PHASE = 3;
	localparam int LONG_HOLD      = 80;
	// The register index past the last defined register; the block must ignore it.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

	typedef enum logic {
		ROW_CFG,
		ROW_SAMPLE
	} row_kind_t;

	// One line of the directed plan: either a register write or one request.
	// For requests whose drive is obvious, the expected value is typed in and
	// replaces the predicted one.
	typedef struct packed {
		row_kind_t                    kind;
		logic [CFG_INDEX_WIDTH-1:0]   index;
		logic [CFG_DATA_WIDTH-1:0]    data;
		logic signed [DATA_WIDTH-1:0] target;
		logic signed [DATA_WIDTH-1:0] current;
		logic                         known;
		logic signed [DATA_WIDTH-1:0] drive;
	} plan_row_t;

	localparam int PLAN_ROWS = 28;

	// The directed plan. It starts at reset values (zero limits force a zero drive),
	// then checks pure proportional action inside a wide deadband, the full-scale
	// error extremes with extreme integral and derivative gains and a zero deadband,
	// incremental mode, a zero drive limit, a switch back to positional mode with state
	// carried over, a zero integral limit, and a write to an index that holds no register.
	localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sh8000, 16'sh7FFF, 1'b1, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sd0,    16'sd0,    1'b1, 16'sd0},
		'{ROW_CFG,    REG_OUT_LIMIT, 16'h7FFF, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_GAIN_P,    16'h0100, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_DEADBAND,  16'hFFFF, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sd100,  16'sd40,   1'b1, 16'sd60},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, -16'sd50,  16'sd50,   1'b1, -16'sd100},
		'{ROW_CFG,    REG_SUM_LIMIT, 16'hFFFF, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_GAIN_I,    16'h7FFF, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_GAIN_D,    16'h8000, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_DEADBAND,  16'h0000, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_MODE,      16'h0001, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sd1,    16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_OUT_LIMIT, 16'h0000, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sd123,  -16'sd7,   1'b1, 16'sd0},
		'{ROW_CFG,    REG_OUT_LIMIT, 16'hFFFF, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_MODE,      16'h0000, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_SUM_LIMIT, 16'h0000, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, -16'sd1,   16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'sd0},
		'{ROW_CFG,    REG_UNUSED,    16'hFFFF, 16'sd0,    16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_MODE,      16'h0000, 16'sd5,    16'sd3,    1'b0, 16'sd0}
	};

	logic                         clk;
	logic                         arst_n;
	logic                         sample_valid;
	logic                         sample_ready;
	logic signed [DATA_WIDTH-1:0] target;
	logic signed [DATA_WIDTH-1:0] current;
	logic                         drive_valid;
	logic                         drive_ready;
	logic signed [DATA_WIDTH-1:0] drive;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0]   cfg_index;
	logic [CFG_DATA_WIDTH-1:0]    cfg_data;

	pid_positional_incremental #(
		.DATA_WIDTH    (DATA_WIDTH),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.target      (target),
		.current     (current),
		.drive_valid (drive_valid),
		.drive_ready (drive_ready),
		.drive       (drive),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// The controller as the testbench sees it: its own copy of the registers
	// and of the loop state, updated once per accepted request.
	cfg_t                          ctl_cfg;
	logic signed [STATE_WIDTH-1:0] integ;
	logic signed [DATA_WIDTH:0]    last_err;
	logic signed [DATA_WIDTH:0]    older_err;
	logic signed [DATA_WIDTH-1:0]  held_drive;

	// Drives predicted for accepted requests, oldest first.
	logic signed [DATA_WIDTH-1:0] drive_expected [$];
	logic signed [DATA_WIDTH-1:0] drive_wanted;
	int drive_mismatches;

	// Sender burst state and the request for one long receiver hold-off.
	int burst_left;
	bit no_gaps;
	bit hold_request;

	// Slowly moving plant used to build realistic tracking sequences.
	int set_point;
	int plant_value;

	// A Q8.8 gain product, shifted with rounding toward minus infinity.
	function automatic longint gain_product(longint x, logic [GAIN_WIDTH-1:0] gain);
		return (x * longint'($signed(gain))) >>> GAIN_FRAC_BITS;
	endfunction

	function automatic longint clamp_to(longint x, logic [LIMIT_WIDTH-1:0] lim);
		longint bound;
		bound = longint'(lim);
		if (x > bound)
			return bound;
		if (x < -bound)
			return -bound;
		return x;
	endfunction

	function automatic void reset_controller();
		ctl_cfg            = '0;
		ctl_cfg.mode       = MODE_POSITIONAL;
		ctl_cfg.deadband   = DEADBAND_RESET;
		integ              = '0;
		last_err           = '0;
		older_err          = '0;
		held_drive         = '0;
	endfunction

	function automatic void apply_register(logic [CFG_INDEX_WIDTH-1:0] index,
			logic [CFG_DATA_WIDTH-1:0] data);
		case (index)
			REG_MODE:      ctl_cfg.mode      = data[0];
			REG_GAIN_P:    ctl_cfg.gain_p    = data;
			REG_GAIN_I:    ctl_cfg.gain_i    = data;
			REG_GAIN_D:    ctl_cfg.gain_d    = data;
			REG_SUM_LIMIT: ctl_cfg.sum_limit = data[LIMIT_WIDTH-1:0];
			REG_OUT_LIMIT: ctl_cfg.out_limit = data[LIMIT_WIDTH-1:0];
			REG_DEADBAND:  ctl_cfg.deadband  = data;
			default: ;
		endcase
	endfunction

	// Works out the drive for one request and advances the loop state.
	// All sums are formed at full width before the clamps.
	function automatic logic signed [DATA_WIDTH-1:0] predict_drive(
			logic signed [DATA_WIDTH-1:0] t, logic signed [DATA_WIDTH-1:0] c);
		longint err;
		longint slope;
		longint bend;
		longint window;
		longint drv;
		err   = longint'(t) - longint'(c);
		slope = err - last_err;
		if (ctl_cfg.mode == MODE_POSITIONAL) begin
			window = longint'(ctl_cfg.deadband);
			integ  = STATE_WIDTH'(clamp_to(integ + gain_product(err, ctl_cfg.gain_i),
				ctl_cfg.sum_limit));
			drv = gain_product(err, ctl_cfg.gain_p);
			// Outside the deadband the integral and derivative terms join in.
			if (!(-window < slope && slope < window))
				drv = drv + integ + gain_product(slope, ctl_cfg.gain_d);
		end else begin
			bend = err - 2 * last_err + older_err;
			drv  = held_drive + gain_product(slope, ctl_cfg.gain_p)
				+ gain_product(err, ctl_cfg.gain_i) + gain_product(bend, ctl_cfg.gain_d);
			older_err = last_err;
		end
		drv        = clamp_to(drv, ctl_cfg.out_limit);
		last_err   = (DATA_WIDTH + 1)'(err);
		held_drive = DATA_WIDTH'(drv);
		return DATA_WIDTH'(drv);
	endfunction

	// Offers one request; called at a falling edge and returns at one. Valid stays high
	// on return, so the caller either offers the next request right away or lowers valid.
	// Between bursts, unless no_gaps is set, the sender idles for a random number of cycles.
	task automatic offer_sample(input logic signed [DATA_WIDTH-1:0] t,
			input logic signed [DATA_WIDTH-1:0] c, input logic known,
			input logic signed [DATA_WIDTH-1:0] known_drive);
		logic signed [DATA_WIDTH-1:0] predicted;
		if (burst_left == 0) begin
			if (!no_gaps) begin
				sample_valid = 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		target       = t;
		current      = c;
		sample_valid = 1'b1;
		do @(posedge clk); while (!sample_ready);
		predicted = predict_drive(t, c);
		drive_expected.push_back(known ? known_drive : predicted);
		@(negedge clk);
	endtask

	// Writes one register once the controller has delivered every drive it owes.
	// Every request gives a drive, so a short pause after the last one suffices.
	task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
			input logic [CFG_DATA_WIDTH-1:0] data);
		sample_valid = 1'b0;
		while (drive_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_index = index;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		apply_register(index, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost drive ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// Receiver. It stalls on a 16-bit pattern that is redrawn each time it runs
	// out: about a third of the patterns never stall. When asked, it holds off for
	// a long stretch so that the controller fills up and pushes back on requests.
	initial begin
		int hold_left;
		int pat_pos;
		logic [15:0] stall_word;
		hold_left   = 0;
		pat_pos     = 0;
		stall_word  = '1;
		drive_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				drive_ready = 1'b0;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD - 1;
				drive_ready  = 1'b0;
			end else begin
				if (pat_pos == 0)
					stall_word = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
				drive_ready = stall_word[pat_pos];
				pat_pos     = (pat_pos + 1) % 16;
			end
		end
	end

	// Checker: every drive taken by the receiver is matched against the oldest
	// prediction. Sampling at the rising edge sees the values from before it.
	always @(posedge clk) begin
		if (arst_n && drive_valid && drive_ready) begin
			if (drive_expected.size() == 0) begin
				$error("drive: expected none, actual %0d", drive);
				drive_mismatches++;
			end else begin
				drive_wanted = drive_expected.pop_front();
				if (drive !== drive_wanted) begin
					$error("drive: expected %0d, actual %0d", drive_wanted, drive);
					drive_mismatches++;
				end
			end
		end
	end

	// Main sequence: reset, the directed plan, then random phases with new
	// register settings each time, then drain and report.
	initial begin
		logic signed [DATA_WIDTH-1:0] t;
		logic signed [DATA_WIDTH-1:0] c;
		logic [CFG_DATA_WIDTH-1:0]    value;
		int                           reg_idx;

		arst_n           = 1'b0;
		sample_valid     = 1'b0;
		target           = '0;
		current          = '0;
		cfg_valid        = 1'b0;
		cfg_index        = REG_MODE;
		cfg_data         = '0;
		burst_left       = 0;
		no_gaps          = 1'b0;
		hold_request     = 1'b0;
		drive_mismatches = 0;
		set_point        = 0;
		plant_value      = 0;
		reset_controller();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_PLAN[i]) begin
			if (DIRECTED_PLAN[i].kind == ROW_CFG)
				write_register(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].data);
			else
				offer_sample(DIRECTED_PLAN[i].target, DIRECTED_PLAN[i].current,
					DIRECTED_PLAN[i].known, DIRECTED_PLAN[i].drive);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// The first two phases pin every register to an extreme; later phases
			// rewrite a random subset, with gains mostly small so the loop does
			// not sit on its limits all the time.
			for (int r = REG_MODE; r <= REG_DEADBAND; r++) begin
				reg_idx = r;
				if (phase == 0) begin
					value = (reg_idx == REG_MODE) ? 16'(MODE_INCREMENTAL)
						: (reg_idx == REG_DEADBAND) ? 16'hFFFF : 16'h7FFF;
				end else if (phase == 1) begin
					value = (reg_idx == REG_MODE) ? 16'(MODE_POSITIONAL)
						: (reg_idx == REG_GAIN_P || reg_idx == REG_GAIN_I
						|| reg_idx == REG_GAIN_D) ? 16'h8000 : 16'h0000;
				end else begin
					if ($urandom_range(0, 2) == 0 && reg_idx != REG_MODE)
						continue;
					case (reg_idx)
						REG_MODE:
							value = 16'($urandom_range(0, 1));
						REG_GAIN_P, REG_GAIN_I, REG_GAIN_D:
							value = ($urandom_range(0, 3) == 0) ? 16'($urandom)
								: 16'(int'($urandom_range(0, 1023)) - 512);
						REG_SUM_LIMIT, REG_OUT_LIMIT:
							case ($urandom_range(0, 3))
								0: value = 16'h0000;
								1: value = 16'h7FFF;
								2: value = 16'($urandom);
								default: value = 16'($urandom_range(1, 4000));
							endcase
						default:
							case ($urandom_range(0, 4))
								0: value = 16'h0000;
								1: value = 16'h0001;
								2: value = 16'hFFFF;
								3: value = 16'($urandom);
								default: value = 16'($urandom_range(2, 64));
							endcase
					endcase
				end
				write_register(reg_idx[CFG_INDEX_WIDTH-1:0], value);
			end
			if (phase == RANDOM_PHASES - 1)
				write_register(REG_UNUSED, 16'($urandom));

			// In the pressure phase the sender never pauses while the receiver
			// holds off, so the controller's input must stall.
			no_gaps = (phase == PRESSURE_PHASE);
			if (phase == PRESSURE_PHASE)
				hold_request = 1'b1;

			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				// Most requests follow a plant creeping toward a set point, which
				// keeps error changes small enough to exercise the deadband and
				// the integral clamp; the rest are noise and full-scale extremes.
				case ($urandom_range(0, 9))
					0: begin
						t = 16'($urandom);
						c = 16'($urandom);
					end
					1: begin
						t = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
						c = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					end
					default: begin
						if ($urandom_range(0, 19) == 0)
							set_point = int'($urandom_range(0, 65535)) - 32768;
						plant_value = plant_value + (set_point - plant_value) / 8
							+ int'($urandom_range(0, 64)) - 32;
						if (plant_value > 32767)
							plant_value = 32767;
						if (plant_value < -32768)
							plant_value = -32768;
						t = 16'(set_point);
						c = 16'(plant_value);
					end
				endcase
				offer_sample(t, c, 1'b0, '0);
			end
		end

		// Drain: wait for every owed drive, then give the pipeline time to show
		// any drive it should not produce.
		sample_valid = 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (drive_mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[pid_positional_incremental.f]
rtl/pidpi_pkg.sv
rtl/pidpi_cfg_regs.sv
rtl/pidpi_datapath.sv
rtl/pid_positional_incremental.sv
tb/pid_positional_incremental_test.sv
